FILE: src/sfd_pkg.sv
// Shared types, widths and helpers for the stereo feedback delay.
// No dependencies.
package sfd_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int DELAY_FRAC_BITS = 8;
    localparam int GUARD_BITS      = 8;
    localparam int COEF_BITS       = 16;
    localparam int TARGET_BITS     = 16 + DELAY_FRAC_BITS;
    localparam int CUR_BITS        = TARGET_BITS + GUARD_BITS;
    localparam int CUR_FRAC        = DELAY_FRAC_BITS + GUARD_BITS;
    localparam int IP_BITS         = CUR_BITS - CUR_FRAC;
    localparam int DAMP_BITS       = SAMPLE_BITS + GUARD_BITS;
    localparam int CFG_DATA_BITS   = TARGET_BITS;
    localparam int CFG_IDX_BITS    = 3;

    // shared multiplier operands: wide signed operand, 16 bit coefficient plus sign
    localparam int MA_BITS = CUR_BITS + 1;
    localparam int MB_BITS = COEF_BITS + 1;
    localparam int P_BITS  = MA_BITS + MB_BITS;

    localparam int COEF_SHIFT  = 16;
    localparam int GAIN_SHIFT  = 15;
    localparam int FB_BITS     = SAMPLE_BITS + 2;
    localparam int SAT_IN_BITS = 40;

    localparam logic [TARGET_BITS-1:0] TARGET_RESET   = TARGET_BITS'(4300800);
    localparam logic [COEF_BITS-1:0]   SMOOTH_RESET   = COEF_BITS'(46);
    localparam logic [COEF_BITS-1:0]   DAMP_RESET     = COEF_BITS'(65535);
    localparam logic [COEF_BITS-1:0]   FB_GAIN_RESET  = COEF_BITS'(16384);
    localparam logic [COEF_BITS-1:0]   WET_MIX_RESET  = COEF_BITS'(9830);
    localparam logic [CUR_BITS-1:0]    CUR_RESET      = CUR_BITS'(TARGET_RESET) << GUARD_BITS;
    localparam logic signed [MB_BITS-1:0] UNITY_GAIN  = MB_BITS'(32768);

    localparam longint SAMPLE_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 64'sd1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TARGET_DELAY  = 3'd0,
        CFG_SMOOTH_COEF   = 3'd1,
        CFG_DAMP_COEF     = 3'd2,
        CFG_FEEDBACK_GAIN = 3'd3,
        CFG_WET_MIX       = 3'd4,
        CFG_PING_PONG     = 3'd5,
        CFG_BYPASS        = 3'd6,
        CFG_STEREO        = 3'd7
    } t_cfg_idx;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_GLIDE = 17'h00002,
        S_CUR   = 17'h00004,
        S_ADDR  = 17'h00008,
        S_RDA   = 17'h00010,
        S_RDB   = 17'h00020,
        S_TAPO  = 17'h00040,
        S_TAPP  = 17'h00080,
        S_TAP   = 17'h00100,
        S_DMPP  = 17'h00200,
        S_DMP   = 17'h00400,
        S_FBP   = 17'h00800,
        S_FB    = 17'h01000,
        S_WMP   = 17'h02000,
        S_DRY   = 17'h04000,
        S_DRP   = 17'h08000,
        S_OUT   = 17'h10000
    } t_state;

    // clamp to the sample range
    function automatic t_sample sat_sample(input logic signed [SAT_IN_BITS-1:0] v);
        t_sample r;
        if (v > SAT_IN_BITS'(SAMPLE_HI)) begin
            r = SAMPLE_BITS'(SAMPLE_HI);
        end else if (v < SAT_IN_BITS'(SAMPLE_LO)) begin
            r = SAMPLE_BITS'(SAMPLE_LO);
        end else begin
            r = SAMPLE_BITS'(v);
        end
        return r;
    endfunction

endpackage

FILE: src/stereo_feedback_delay.sv
// Stereo feedback delay with delay glide, damping low-pass and ping-pong. One input beat
// carries a stereo pair of Q1.23 samples and gives exactly one output beat. An item is taken
// only while the block is idle. From its accepting edge the sequencer steps from S_GLIDE
// through the tap, damping, feedback and mix states to S_OUT and back to idle, so a new beat
// is taken only after the previous result is loaded into the output register (in bypass it
// goes from idle straight to S_OUT); a result waiting on a stalled output holds it in S_OUT.
// The sequence is set by one 33x17 multiplier per channel that serves six products in turn
// (glide on the left lane only, interpolation, damping, feedback, wet and dry share) and by
// the two reads of each delay memory. After reset both delay memories are cleared, one entry
// a cycle, through all MAX_DELAY entries while the input is stalled; configuration writes are
// taken during that pass. Write configuration only while idle; the block does not enforce it.
// Depends on sfd_pkg and sfd_ram.
module stereo_feedback_delay #(
    parameter int MAX_DELAY = 65536
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] i_right_in,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0] o_right_out,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    import sfd_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    // integer part is below 2^16 and MAX_DELAY at least 1024, so six halvings reduce it
    localparam int MOD_STEPS = 6;
    localparam int IP_LIMIT  = (1 << IP_BITS) - 1;

    // integer delay modulo MAX_DELAY by restoring subtraction of MAX_DELAY << j
    function automatic logic [AW-1:0] wrap_ip(input logic [IP_BITS-1:0] ip);
        logic [IP_BITS-1:0] r;
        r = ip;
        for (int j = MOD_STEPS - 1; j >= 0; j--) begin
            if ((MAX_DELAY << j) <= IP_LIMIT) begin
                if (r >= IP_BITS'(MAX_DELAY << j)) begin
                    r = r - IP_BITS'(MAX_DELAY << j);
                end
            end
        end
        return AW'(r);
    endfunction

    // ---------------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------------
    logic [TARGET_BITS-1:0] r_target;
    logic [COEF_BITS-1:0]   r_smooth;
    logic [COEF_BITS-1:0]   r_damp_coef;
    logic [COEF_BITS-1:0]   r_fb_gain;
    logic [COEF_BITS-1:0]   r_wet_mix;
    logic                   r_ping_pong;
    logic                   r_bypass;
    logic                   r_stereo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_RESET;
            r_smooth    <= SMOOTH_RESET;
            r_damp_coef <= DAMP_RESET;
            r_fb_gain   <= FB_GAIN_RESET;
            r_wet_mix   <= WET_MIX_RESET;
            r_ping_pong <= 1'b0;
            r_bypass    <= 1'b0;
            r_stereo    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET_DELAY:  r_target    <= i_cfg_data[TARGET_BITS-1:0];
                CFG_SMOOTH_COEF:   r_smooth    <= i_cfg_data[COEF_BITS-1:0];
                CFG_DAMP_COEF:     r_damp_coef <= i_cfg_data[COEF_BITS-1:0];
                CFG_FEEDBACK_GAIN: r_fb_gain   <= i_cfg_data[COEF_BITS-1:0];
                CFG_WET_MIX:       r_wet_mix   <= i_cfg_data[COEF_BITS-1:0];
                CFG_PING_PONG:     r_ping_pong <= i_cfg_data[0];
                CFG_BYPASS:        r_bypass    <= i_cfg_data[0];
                CFG_STEREO:        r_stereo    <= i_cfg_data[0];
            endcase
        end
    end

    // ---------------------------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------------------------
    t_state         r_state, n_state;
    logic           r_clr;          // clearing pass after reset in progress
    logic [AW-1:0]  r_clr_addr;
    logic [AW-1:0]  r_wp;           // next slot to write
    logic [CUR_BITS-1:0] r_cur;     // current (gliding) delay, 16 fraction bits
    logic [AW-1:0]  r_ia;           // newer interpolation tap
    logic [AW-1:0]  r_ib;           // older interpolation tap
    logic           r_out_valid;

    // lane 0 is left, lane 1 right
    logic signed [DAMP_BITS-1:0] r_damp [2];

    // datapath registers, no reset
    t_sample                   r_in   [2];
    t_sample                   r_a    [2];
    t_sample                   r_wet  [2];
    logic signed [FB_BITS-1:0] r_fb   [2];
    logic signed [MA_BITS-1:0] r_ma   [2];
    logic signed [MB_BITS-1:0] r_mb   [2];
    logic signed [P_BITS-1:0]  r_p    [2];
    logic signed [P_BITS-1:0]  r_acc  [2];
    t_sample                   r_out  [2];

    logic signed [P_BITS-1:0]  prod   [2];
    t_sample                   rdata  [2];
    t_sample                   wdata  [2];
    t_sample                   mix    [2];
    logic signed [FB_BITS-1:0] fb_x   [2];
    logic signed [P_BITS:0]    mix_sum[2];
    t_sample                   tap    [2];
    logic signed [DAMP_BITS-1:0] damp_nx[2];

    logic           accept;
    logic           out_free;
    logic           out_load;
    logic           line_we;
    logic [AW-1:0]  raddr;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  ip_wrapped;
    logic [AW-1:0]  ia_nx;
    logic signed [MB_BITS-1:0] dry_gain;

    assign o_in_stall = r_clr || (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // output register parts the output side from the sequencer
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_OUT) && out_free;
    assign line_we  = out_load && !r_bypass;

    assign dry_gain = UNITY_GAIN - $signed({1'b0, r_wet_mix});

    // read pointer: integer delay behind the write pointer, modulo memory depth
    assign ip_wrapped = wrap_ip(r_cur[CUR_BITS-1:CUR_FRAC]);
    assign ia_nx = (r_wp >= ip_wrapped) ? (r_wp - ip_wrapped)
                 : AW'((AW+1)'(r_wp) + (AW+1)'(MAX_DELAY) - (AW+1)'(ip_wrapped));

    assign raddr = (r_state == S_RDB) ? r_ib : r_ia;
    assign waddr = r_clr ? r_clr_addr : r_wp;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            prod[l]    = r_ma[l] * r_mb[l];
            tap[l]     = r_a[l] + $signed(r_p[l][CUR_FRAC +: SAMPLE_BITS]);
            damp_nx[l] = r_damp[l] + $signed(r_p[l][COEF_SHIFT +: DAMP_BITS]);
            mix_sum[l] = (P_BITS+1)'(r_acc[l]) + (P_BITS+1)'(r_p[l]);
            mix[l]     = sat_sample(SAT_IN_BITS'($signed(mix_sum[l][P_BITS:GAIN_SHIFT])));
        end
        // ping-pong crosses the feedback paths, stereo only
        if (r_ping_pong && r_stereo) begin
            fb_x[0] = r_fb[1];
            fb_x[1] = r_fb[0];
        end else begin
            fb_x[0] = r_fb[0];
            fb_x[1] = r_fb[1];
        end
        for (int l = 0; l < 2; l++) begin
            if (r_clr) begin
                wdata[l] = '0;
            end else begin
                wdata[l] = sat_sample(SAT_IN_BITS'(r_in[l]) + SAT_IN_BITS'(fb_x[l]));
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_line
        sfd_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (MAX_DELAY)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (r_clr || line_we),
            .i_waddr (waddr),
            .i_wdata (wdata[g]),
            .i_raddr (raddr),
            .o_rdata (rdata[g])
        );
    end

    // ---------------------------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) begin
                         n_state = r_bypass ? S_OUT : S_GLIDE;
                     end
            S_GLIDE: n_state = S_CUR;
            S_CUR:   n_state = S_ADDR;
            S_ADDR:  n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_TAPO;
            S_TAPO:  n_state = S_TAPP;
            S_TAPP:  n_state = S_TAP;
            S_TAP:   n_state = S_DMPP;
            S_DMPP:  n_state = S_DMP;
            S_DMP:   n_state = S_FBP;
            S_FBP:   n_state = S_FB;
            S_FB:    n_state = S_WMP;
            S_WMP:   n_state = S_DRY;
            S_DRY:   n_state = S_DRP;
            S_DRP:   n_state = S_OUT;
            S_OUT:   if (out_free) begin
                         n_state = S_IDLE;
                     end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_cur       <= CUR_RESET;
            r_out_valid <= 1'b0;
            r_damp[0]   <= '0;
            r_damp[1]   <= '0;
        end else begin
            r_state <= n_state;

            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAX_DELAY - 1)) begin
                    r_clr <= 1'b0;
                end
            end

            // glide: current delay moves a fraction of the way to the target
            if (r_state == S_CUR) begin
                r_cur <= r_cur + r_p[0][COEF_SHIFT +: CUR_BITS];
            end

            if (r_state == S_DMP) begin
                r_damp[0] <= damp_nx[0];
                r_damp[1] <= damp_nx[1];
            end

            if (line_we) begin
                r_wp <= (r_wp == AW'(MAX_DELAY - 1)) ? '0 : r_wp + 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: operands are registered, the product is registered every cycle
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_p[l] <= prod[l];
        end

        if (accept) begin
            r_in[0] <= i_left_in;
            r_in[1] <= r_stereo ? i_right_in : i_left_in;
            r_ma[0] <= $signed({1'b0, r_target, {GUARD_BITS{1'b0}}}) - $signed({1'b0, r_cur});
            r_mb[0] <= $signed({1'b0, r_smooth});
        end

        if (r_state == S_ADDR) begin
            r_ia <= ia_nx;
        end
        if (r_state == S_RDA) begin
            r_ib <= (r_ia == '0) ? AW'(MAX_DELAY - 1) : r_ia - 1'b1;
        end

        for (int l = 0; l < 2; l++) begin
            case (r_state)
                S_RDB: begin
                    r_a[l] <= rdata[l];
                end
                S_TAPO: begin
                    // older minus newer sample, scaled by the delay fraction
                    r_ma[l] <= MA_BITS'(rdata[l]) - MA_BITS'(r_a[l]);
                    r_mb[l] <= $signed({1'b0, r_cur[CUR_FRAC-1:0]});
                end
                S_TAP: begin
                    r_ma[l] <= MA_BITS'($signed({tap[l], {GUARD_BITS{1'b0}}}))
                             - MA_BITS'(r_damp[l]);
                    r_mb[l] <= $signed({1'b0, r_damp_coef});
                end
                S_DMP: begin
                    r_wet[l] <= damp_nx[l][DAMP_BITS-1:GUARD_BITS];
                    r_ma[l]  <= MA_BITS'($signed(damp_nx[l][DAMP_BITS-1:GUARD_BITS]));
                    r_mb[l]  <= $signed({1'b0, r_fb_gain});
                end
                S_FB: begin
                    r_fb[l] <= $signed(r_p[l][GAIN_SHIFT +: FB_BITS]);
                    r_ma[l] <= MA_BITS'(r_wet[l]);
                    r_mb[l] <= $signed({1'b0, r_wet_mix});
                end
                S_DRY: begin
                    r_acc[l] <= r_p[l];
                    r_ma[l]  <= MA_BITS'(r_in[l]);
                    r_mb[l]  <= dry_gain;
                end
                default: begin
                end
            endcase
        end

        if (out_load) begin
            if (r_bypass) begin
                r_out[0] <= r_in[0];
                r_out[1] <= r_in[1];
            end else begin
                r_out[0] <= mix[0];
                r_out[1] <= r_stereo ? mix[1] : mix[0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out[0];
    assign o_right_out = r_out[1];

endmodule

FILE: src/sfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
